// ===== hw/rtl/fieldbus_board_sync_scheduler_macros.svh =====
// Assertion macros shared by the checker of the board sync scheduler.
// Depends on nothing; included by the checker file.
`ifndef FIELDBUS_BOARD_SYNC_SCHEDULER_MACROS_SVH
`define FIELDBUS_BOARD_SYNC_SCHEDULER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define FBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== hw/rtl/fbss_pkg.sv =====
// Package of the board sync scheduler: payload structs, codes, constants.
// Depends on nothing.
package fbss_pkg;
	localparam int BOARD_SLOTS = 16;
	localparam int COUNTER_BITS = 8;
	localparam int SLOT_W = 4;
	localparam logic [4:0] FULL_TASKS = 5'h1f;
	localparam logic [2:0] ERR_RST = 3'b001;
	localparam logic [2:0] ERR_CSUM = 3'b010;
	localparam logic [2:0] ERR_LNK = 3'b100;
	localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

	typedef enum logic [2:0] {
		ACT_TICK, ACT_BUS_DONE, ACT_MOUNT, ACT_UNMOUNT,
		ACT_REQUEST, ACT_WRITE, ACT_RESET_ERR, ACT_READ
	} action_t;

	typedef enum logic [2:0] {
		KIND_ACK, KIND_ISSUE, KIND_ABORT, KIND_MOUNT, KIND_STATS
	} kind_t;

	typedef enum logic [1:0] {
		CFG_READ_PERIOD, CFG_KEEPALIVE_PERIOD, CFG_RESET_LIMIT, CFG_LINK_LIMIT
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_CLOSE, ST_SCAN, ST_START, ST_OUT
	} state_t;

	typedef struct packed {
		logic [2:0] action;
		logic [3:0] slot;
		logic [7:0] board_addr;
		logic [2:0] task_code;
		logic [1:0] bus_status;
		logic board_was_reset;
		logic [31:0] write_value;
		logic [31:0] write_mask;
	} in_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] bus_addr;
		logic [2:0] command_task;
		logic [3:0] reply_slot;
		logic reply_ok;
		logic [7:0] reset_count;
		logic [7:0] link_error_count;
		logic [2:0] permanent_errors;
		logic [7:0] last_bad_addr;
		logic [31:0] discrete_value;
		logic syncing;
	} out_item_t;

	typedef struct packed {
		logic exec;
		logic close;
		logic scan;
		logic start;
	} fbss_cmd_t;

	typedef struct packed {
		logic need_close;
		logic need_scan;
	} fbss_sts_t;

	function automatic logic [2:0] low_bit(input logic [4:0] v);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 4; i >= 0; i--) begin
			if (v[i]) r = 3'(i);
		end
		return r;
	endfunction

	function automatic logic [7:0] bus_address(input logic [7:0] a);
		logic [7:0] m;
		m = a;
		if (m >= 8'd200) m = m - 8'd200;
		else if (m >= 8'd100) m = m - 8'd100;
		return m + 8'd120;
	endfunction
endpackage

// ===== hw/rtl/fbss_ctrl.sv =====
// Controller state machine of the board sync scheduler.
// Depends on fbss_pkg.
module fbss_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic out_fire,
	input fbss_pkg::fbss_sts_t sts,
	output fbss_pkg::fbss_cmd_t cmd,
	output logic in_ready,
	output logic out_valid
);
	import fbss_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_EXEC;
			ST_EXEC: begin
				if (sts.need_close) state_d = ST_CLOSE;
				else if (sts.need_scan) state_d = ST_SCAN;
				else state_d = ST_OUT;
			end
			ST_CLOSE: state_d = ST_SCAN;
			ST_SCAN: state_d = ST_START;
			ST_START: state_d = ST_OUT;
			ST_OUT: if (out_fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EXEC: cmd.exec = 1'b1;
			ST_CLOSE: cmd.close = 1'b1;
			ST_SCAN: cmd.scan = 1'b1;
			ST_START: cmd.start = 1'b1;
			ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule

// ===== hw/rtl/fbss_datapath.sv =====
// Datapath of the board sync scheduler: slot tables, timers and result build.
// Depends on fbss_pkg.
module fbss_datapath (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input fbss_pkg::in_item_t in_item,
	input logic cfg_fire,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data,
	input fbss_pkg::fbss_cmd_t cmd,
	output fbss_pkg::fbss_sts_t sts,
	output fbss_pkg::out_item_t result
);
	import fbss_pkg::*;

	logic [15:0] read_period_q, keep_period_q;
	logic [7:0] reset_limit_q, link_limit_q;
	logic [BOARD_SLOTS-1:0] used_q;
	logic [7:0] addr_q [BOARD_SLOTS];
	logic [4:0] req_q [BOARD_SLOTS];
	logic [4:0] pend_q [BOARD_SLOTS];
	logic [2:0] serr_q [BOARD_SLOTS];
	logic [COUNTER_BITS-1:0] rst_cnt_q [BOARD_SLOTS];
	logic [COUNTER_BITS-1:0] lnk_cnt_q [BOARD_SLOTS];
	logic [2:0] sticky_q [BOARD_SLOTS];
	logic [31:0] disc_q [BOARD_SLOTS];
	logic [SLOT_W-1:0] act_q;
	logic act_valid_q, busy_q;
	logic [15:0] read_dly_q, keep_dly_q;
	logic [7:0] bad_addr_q;
	in_item_t item_q;
	out_item_t res_q;
	logic found_q;
	logic [SLOT_W-1:0] pick_q;

	logic ok;
	logic [BOARD_SLOTS-1:0] dirty;
	logic [BOARD_SLOTS-1:0] match_vec;
	logic [SLOT_W-1:0] s;
	logic [SLOT_W-1:0] a;
	logic [4:0] p;
	logic [4:0] p_rest;
	logic [31:0] nv;
	logic rd_hit, ka_hit;
	logic [15:0] rd_next, ka_next;
	logic scan_found;
	logic [SLOT_W-1:0] scan_pick;
	logic mnt_hit, free_hit;
	logic [SLOT_W-1:0] mnt_slot, free_slot;
	logic [COUNTER_BITS-1:0] rst_inc, lnk_inc;
	logic rst_over, lnk_over;
	logic [4:0] start_tasks;
	out_item_t res_exec, res_start;

	assign s = item_q.slot;
	assign a = act_q;
	assign ok = 32'(s) < BOARD_SLOTS;
	assign p = pend_q[a];
	assign p_rest = p & (p - 5'd1);
	assign nv = (disc_q[s] & ~item_q.write_mask) | (item_q.write_value & item_q.write_mask);
	assign start_tasks = pend_q[pick_q] | req_q[pick_q];

	always_comb begin
		for (int i = 0; i < BOARD_SLOTS; i++) begin
			dirty[i] = used_q[i] && ((pend_q[i] | req_q[i]) != 5'd0);
			match_vec[i] = used_q[i] && (addr_q[i] == item_q.board_addr);
		end
	end

	always_comb begin
		rd_hit = 1'b0;
		rd_next = read_dly_q;
		if (read_dly_q != 16'd0) rd_next = read_dly_q - 16'd1;
		if (rd_next == 16'd0) begin
			rd_hit = 1'b1;
			rd_next = (read_period_q == 16'd0) ? 16'd0 : read_period_q - 16'd1;
		end
		ka_hit = 1'b0;
		ka_next = keep_dly_q;
		if (keep_dly_q != 16'd0) ka_next = keep_dly_q - 16'd1;
		if (ka_next == 16'd0) begin
			ka_hit = 1'b1;
			ka_next = (keep_period_q == 16'd0) ? 16'd0 : keep_period_q - 16'd1;
		end
	end

	always_comb begin
		scan_found = 1'b0;
		scan_pick = '0;
		if (act_valid_q) begin
			for (int i = BOARD_SLOTS - 1; i >= 0; i--) begin
				if (dirty[i] && 32'(i) > 32'(a)) begin
					scan_found = 1'b1;
					scan_pick = SLOT_W'(i);
				end
			end
		end
		if (!scan_found) begin
			for (int i = BOARD_SLOTS - 1; i >= 0; i--) begin
				if (dirty[i]) begin
					scan_found = 1'b1;
					scan_pick = SLOT_W'(i);
				end
			end
		end
		mnt_hit = 1'b0;
		mnt_slot = '0;
		free_hit = 1'b0;
		free_slot = '0;
		for (int i = BOARD_SLOTS - 1; i >= 0; i--) begin
			if (match_vec[i]) begin
				mnt_hit = 1'b1;
				mnt_slot = SLOT_W'(i);
			end
			if (!used_q[i]) begin
				free_hit = 1'b1;
				free_slot = SLOT_W'(i);
			end
		end
	end

	assign rst_inc = (rst_cnt_q[a] < CNT_MAX) ? rst_cnt_q[a] + 1'b1 : rst_cnt_q[a];
	assign lnk_inc = (lnk_cnt_q[a] < CNT_MAX) ? lnk_cnt_q[a] + 1'b1 : lnk_cnt_q[a];
	assign rst_over = ((serr_q[a] & ERR_RST) != 3'd0) && (32'(rst_inc) > 32'(reset_limit_q));
	assign lnk_over = ((serr_q[a] & (ERR_CSUM | ERR_LNK)) != 3'd0) &&
		(32'(lnk_inc) > 32'(link_limit_q));

	assign sts.need_close = item_q.action == ACT_TICK && used_q != '0 && act_valid_q && !busy_q;
	assign sts.need_scan = item_q.action == ACT_TICK && used_q != '0 && !act_valid_q;

	always_comb begin
		res_exec = '0;
		unique case (action_t'(item_q.action))
			ACT_BUS_DONE: begin
				if (busy_q && act_valid_q && item_q.bus_status == 2'd0 && p != 5'd0 &&
						!(low_bit(p) == 3'd0 && item_q.board_was_reset) && p_rest != 5'd0) begin
					res_exec.kind = KIND_ISSUE;
					res_exec.bus_addr = bus_address(addr_q[a]);
					res_exec.command_task = low_bit(p_rest);
				end
			end
			ACT_MOUNT: begin
				res_exec.kind = KIND_MOUNT;
				if (item_q.board_addr != 8'd0) begin
					if (mnt_hit) begin
						res_exec.reply_slot = 4'(mnt_slot);
						res_exec.reply_ok = 1'b1;
					end else if (free_hit) begin
						res_exec.reply_slot = 4'(free_slot);
						res_exec.reply_ok = 1'b1;
					end
				end
			end
			ACT_UNMOUNT: begin
				if (ok && busy_q && act_valid_q && act_q == s) res_exec.kind = KIND_ABORT;
			end
			ACT_READ: begin
				res_exec.kind = KIND_STATS;
				if (ok) begin
					res_exec.reset_count = 8'(rst_cnt_q[s]);
					res_exec.link_error_count = 8'(lnk_cnt_q[s]);
					res_exec.permanent_errors = sticky_q[s];
					res_exec.last_bad_addr = bad_addr_q;
					res_exec.discrete_value = disc_q[s];
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res_start = '0;
		res_start.kind = KIND_ISSUE;
		res_start.bus_addr = bus_address(addr_q[pick_q]);
		res_start.command_task = low_bit(start_tasks);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_period_q <= 16'd10;
			keep_period_q <= 16'd100;
			reset_limit_q <= 8'd3;
			link_limit_q <= 8'd3;
			used_q <= '0;
			act_q <= '0;
			act_valid_q <= 1'b0;
			busy_q <= 1'b0;
			read_dly_q <= '0;
			keep_dly_q <= '0;
			bad_addr_q <= '0;
			found_q <= 1'b0;
			pick_q <= '0;
			res_q <= '0;
			item_q <= '0;
			for (int i = 0; i < BOARD_SLOTS; i++) begin
				addr_q[i] <= '0;
				req_q[i] <= '0;
				pend_q[i] <= '0;
				serr_q[i] <= '0;
				rst_cnt_q[i] <= '0;
				lnk_cnt_q[i] <= '0;
				sticky_q[i] <= '0;
				disc_q[i] <= '0;
			end
		end else begin
			if (cfg_fire) begin
				unique case (cfg_index_t'(cfg_index))
					CFG_READ_PERIOD: read_period_q <= cfg_data[15:0];
					CFG_KEEPALIVE_PERIOD: keep_period_q <= cfg_data[15:0];
					CFG_RESET_LIMIT: reset_limit_q <= cfg_data[7:0];
					CFG_LINK_LIMIT: link_limit_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_fire) item_q <= in_item;
			if (cmd.exec) begin
				res_q <= res_exec;
				unique case (action_t'(item_q.action))
					ACT_TICK: begin
						if (used_q != '0) begin
							read_dly_q <= rd_next;
							keep_dly_q <= ka_next;
							for (int i = 0; i < BOARD_SLOTS; i++) begin
								if (used_q[i]) begin
									req_q[i] <= req_q[i] | {1'b0, rd_hit, 2'b00, ka_hit};
								end
							end
						end
					end
					ACT_BUS_DONE: begin
						if (busy_q && act_valid_q) begin
							if (item_q.bus_status != 2'd0) begin
								serr_q[a] <= serr_q[a] |
									((item_q.bus_status == 2'd1) ? ERR_CSUM : ERR_LNK);
								busy_q <= 1'b0;
							end else if (p == 5'd0) begin
								busy_q <= 1'b0;
							end else begin
								pend_q[a] <= p_rest;
								if (low_bit(p) == 3'd0 && item_q.board_was_reset) begin
									serr_q[a] <= serr_q[a] | ERR_RST;
									busy_q <= 1'b0;
								end else if (p_rest == 5'd0) begin
									busy_q <= 1'b0;
								end
							end
						end
					end
					ACT_MOUNT: begin
						if (item_q.board_addr != 8'd0 && !mnt_hit && free_hit) begin
							used_q[free_slot] <= 1'b1;
							addr_q[free_slot] <= item_q.board_addr;
							req_q[free_slot] <= FULL_TASKS;
							pend_q[free_slot] <= '0;
							serr_q[free_slot] <= '0;
							rst_cnt_q[free_slot] <= '0;
							lnk_cnt_q[free_slot] <= '0;
							sticky_q[free_slot] <= '0;
							disc_q[free_slot] <= '0;
						end
					end
					ACT_UNMOUNT: begin
						if (ok) begin
							used_q[s] <= 1'b0;
							if (busy_q && act_valid_q && act_q == s) begin
								busy_q <= 1'b0;
								act_valid_q <= 1'b0;
							end
						end
					end
					ACT_REQUEST: begin
						if (ok && item_q.task_code < 3'd5) begin
							req_q[s] <= req_q[s] | (5'd1 << item_q.task_code);
						end
					end
					ACT_WRITE: begin
						if (ok && nv != disc_q[s]) begin
							disc_q[s] <= nv;
							req_q[s] <= req_q[s] | 5'b00100;
						end
					end
					ACT_RESET_ERR: begin
						if (ok) begin
							rst_cnt_q[s] <= '0;
							lnk_cnt_q[s] <= '0;
							sticky_q[s] <= '0;
						end
					end
					default: ;
				endcase
			end
			if (cmd.close && serr_q[a] != 3'd0) begin
				req_q[a] <= req_q[a] | FULL_TASKS;
				sticky_q[a] <= sticky_q[a] | (rst_over ? ERR_RST : 3'd0) |
					(lnk_over ? (serr_q[a] & (ERR_CSUM | ERR_LNK)) : 3'd0);
				if ((serr_q[a] & ERR_RST) != 3'd0) begin
					if (rst_over) begin
						rst_cnt_q[a] <= COUNTER_BITS'(reset_limit_q);
					end else begin
						rst_cnt_q[a] <= rst_inc;
					end
				end
				if ((serr_q[a] & (ERR_CSUM | ERR_LNK)) != 3'd0) begin
					if (lnk_over) begin
						lnk_cnt_q[a] <= COUNTER_BITS'(link_limit_q);
						bad_addr_q <= addr_q[a];
					end else begin
						lnk_cnt_q[a] <= lnk_inc;
					end
				end
			end
			if (cmd.scan) begin
				found_q <= scan_found;
				pick_q <= scan_pick;
			end
			if (cmd.start) begin
				if (!found_q) begin
					act_valid_q <= 1'b0;
				end else begin
					act_q <= pick_q;
					act_valid_q <= 1'b1;
					pend_q[pick_q] <= start_tasks;
					req_q[pick_q] <= '0;
					serr_q[pick_q] <= '0;
					if (start_tasks == 5'd0) begin
						busy_q <= 1'b0;
					end else begin
						busy_q <= 1'b1;
						res_q <= res_start;
					end
				end
			end
		end
	end

	always_comb begin
		result = res_q;
		result.syncing = busy_q;
	end
endmodule

// ===== hw/rtl/fieldbus_board_sync_scheduler.sv =====
// Top level of the board sync scheduler: controller plus datapath.
// Depends on fbss_pkg, fbss_ctrl and fbss_datapath.
//
// One action beat enters on in (in_valid/in_ready) and exactly one result
// beat leaves on out (out_valid/out_ready) for every action.
// Register writes use cfg (cfg_valid/cfg_ready, cfg_index, cfg_data); they are
// always taken and must only be issued while the block is idle.
// For most actions the result beat follows the execute step directly; a tick
// that only searches the pool adds search and start steps, and a tick that
// closes a sync and searches also adds a close step before them.
// The controller walks the close, search and start steps one per cycle.
// A stalled receiver holds the result, and no new action is taken
// until the result beat completes.
// Reset clears all slot tables, timers and state registers and loads the
// configuration registers with their defaults at once; no clearing pass
// is needed.
module fieldbus_board_sync_scheduler (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input fbss_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output fbss_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	import fbss_pkg::*;
	fbss_cmd_t cmd;
	fbss_sts_t sts;
	logic in_fire, out_fire;

	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign cfg_ready = 1'b1;

	fbss_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.sts(sts), .cmd(cmd), .in_ready(in_ready), .out_valid(out_valid)
	);

	fbss_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_item(in_data),
		.cfg_fire(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .sts(sts), .result(out_data)
	);
endmodule

// ===== hw/rtl/fbss_checker.sv =====
// Port-level checker of the board sync scheduler and its bind.
// Depends on fbss_pkg and fieldbus_board_sync_scheduler_macros.svh.
`include "fieldbus_board_sync_scheduler_macros.svh"
module fbss_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input fbss_pkg::out_item_t out_data
);
	import fbss_pkg::*;
	`FBS_ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	`FBS_ASSERT_NEXT(a_in_then_busy, clk, arst_n, in_valid && in_ready, !in_ready)
	`FBS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`FBS_ASSERT_IMP(a_kind_range, clk, arst_n, out_valid, out_data.kind <= KIND_STATS)
	`FBS_ASSERT_IMP(a_issue_addr, clk, arst_n, out_valid && out_data.kind == KIND_ISSUE,
		out_data.bus_addr >= 8'd120 && out_data.bus_addr <= 8'd219)
endmodule

bind fieldbus_board_sync_scheduler fbss_checker u_fbss_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
